[sv/i2c_master_bit_sequencer_macros.svh]
// Assertion macros for the I2C master bit sequencer.
// Expects clk and rst_n in the scope of each use.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define I2CMS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define I2CMS_ASSERT_IMPLY(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define I2CMS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[sv/i2cms_pkg.sv]
// Shared types and codes for the I2C master bit sequencer.
// No dependencies.
package i2cms_pkg;

    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_STOP  = 3'd1;
    localparam logic [2:0] K_SEND  = 3'd2;
    localparam logic [2:0] K_RECV  = 3'd3;
    localparam logic [2:0] K_RACK  = 3'd4;
    localparam logic [2:0] K_SACK  = 3'd5;
    localparam logic [2:0] K_TICK  = 3'd6;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [4:0] MAX_PHASES = 5'd24;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [2:0] cmd;
        logic [4:0] phase;
        logic [7:0] shift;
        logic       ack;
        logic       busy;
    } state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } result_t;

endpackage

[sv/i2cms_step.sv]
// Next-state and result logic for one item of the I2C master bit sequencer.
// Depends on i2cms_pkg.
module i2cms_step
(
    input  i2cms_pkg::state_t  st,
    input  logic [2:0]         kind,
    input  logic [7:0]         tx_byte,
    input  logic               ack_bit,
    input  logic               sda_in,
    output i2cms_pkg::state_t  st_next,
    output i2cms_pkg::result_t res
);
    import i2cms_pkg::*;

    function automatic logic [4:0] seq_len(input logic [2:0] cmd);
        logic [4:0] len;
        begin
            unique case (cmd)
                K_START: len = 5'd4;
                K_SEND:  len = 5'd24;
                K_RECV:  len = 5'd18;
                default: len = 5'd3;
            endcase
            return len;
        end
    endfunction

    function automatic logic [4:0] split3(input logic [4:0] i);
        logic [4:0] base;
        logic [4:0] qr;
        begin
            qr = '0;
            for (int k = 0; k < 8; k++)
            begin
                base = 5'(3 * k);
                if (i >= base && i < base + 5'd3)
                begin
                    qr = {3'(k), 2'(i - base)};
                end
            end
            return qr;
        end
    endfunction

    function automatic state_t apply_change(input state_t s, input logic [4:0] i,
                                            input logic ackv);
        state_t     r;
        logic [4:0] qr;
        begin
            r  = s;
            qr = split3(i);
            unique case (s.cmd)
                K_START:
                begin
                    priority case (i)
                        5'd0:    r.sda = 1'b1;
                        5'd1:    r.scl = 1'b1;
                        5'd2:    r.sda = 1'b0;
                        default: r.scl = 1'b0;
                    endcase
                end
                K_STOP:
                begin
                    priority case (i)
                        5'd0:    r.sda = 1'b0;
                        5'd1:    r.scl = 1'b1;
                        default: r.sda = 1'b1;
                    endcase
                end
                K_SEND:
                begin
                    priority case (qr[1:0])
                        2'd0:    r.sda = |(s.shift & (MSB_MASK >> qr[4:2]));
                        2'd1:    r.scl = 1'b1;
                        default: r.scl = 1'b0;
                    endcase
                end
                K_RECV:
                begin
                    if (i == 5'd0)
                    begin
                        r.sda = 1'b1;
                    end
                    else if (i >= 5'd2)
                    begin
                        r.scl = ~i[0];
                    end
                end
                K_RACK:
                begin
                    priority case (i)
                        5'd0:    r.sda = 1'b1;
                        5'd1:    r.scl = 1'b1;
                        default: r.scl = 1'b0;
                    endcase
                end
                default:
                begin
                    priority case (i)
                        5'd0:    r.sda = ackv;
                        5'd1:    r.scl = 1'b1;
                        default: r.scl = 1'b0;
                    endcase
                end
            endcase
            return r;
        end
    endfunction

    state_t     nx;
    logic [4:0] p1;
    logic       done;
    logic       rej;

    always_comb
    begin
        nx   = st;
        done = 1'b0;
        rej  = 1'b0;
        p1   = st.phase + 5'd1;
        if (kind <= K_SACK)
        begin
            if (st.busy)
            begin
                rej = 1'b1;
            end
            else
            begin
                nx.cmd   = kind;
                nx.phase = '0;
                nx.busy  = 1'b1;
                if (kind == K_SEND)
                begin
                    nx.shift = tx_byte;
                end
                else if (kind == K_RECV)
                begin
                    nx.shift = '0;
                end
                nx = apply_change(nx, 5'd0, ack_bit);
            end
        end
        else if (kind == K_TICK && st.busy)
        begin
            if (st.cmd == K_RECV && st.phase >= 5'd2 && !st.phase[0])
            begin
                nx.shift = {st.shift[6:0], sda_in};
            end
            else if (st.cmd == K_RACK && st.phase == 5'd1)
            begin
                nx.ack = sda_in;
            end
            if (p1 >= seq_len(st.cmd))
            begin
                done     = 1'b1;
                nx.busy  = 1'b0;
                nx.phase = '0;
            end
            else
            begin
                nx.phase = p1;
                nx = apply_change(nx, p1, 1'b0);
            end
        end
    end

    assign st_next       = nx;
    assign res.scl_level = nx.scl;
    assign res.sda_level = nx.sda;
    assign res.busy_res  = nx.busy;
    assign res.done_res  = done;
    assign res.rx_byte   = (nx.cmd == K_RECV) ? nx.shift : 8'd0;
    assign res.ack_seen  = nx.ack;
    assign res.rejected  = rej;

endmodule

[sv/i2c_master_bit_sequencer.sv]
// I2C master bit sequencer: takes one command or tick per cycle and returns the pin
// drives and status after it, unless stalled. Throughput is one transfer per clock while
// no stall holds it. An input transfer lands in the input register, and one step of
// next-state logic feeds the result register, from which each result is offered.
// A stalled result holds the pipeline and stalls the input once both registers are full.
// Depends on i2cms_pkg, i2cms_step and the assertion macro header.
`include "i2c_master_bit_sequencer_macros.svh"

module i2c_master_bit_sequencer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [7:0] tx_byte,
    input  logic       ack_bit,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_level,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_seen,
    output logic       rejected
);
    import i2cms_pkg::*;

    logic       s1_valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] tx_byte_reg;
    logic       ack_bit_reg;
    logic       sda_in_reg;

    state_t     st_reg;
    state_t     st_next;
    result_t    res_next;
    result_t    res_reg;
    logic       out_valid_reg;

    logic       advance;
    logic       in_take;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    i2cms_step u_step
    (
        .st      (st_reg),
        .kind    (kind_reg),
        .tx_byte (tx_byte_reg),
        .ack_bit (ack_bit_reg),
        .sda_in  (sda_in_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{scl: 1'b1, sda: 1'b1, cmd: 3'd0, phase: 5'd0,
                               shift: 8'd0, ack: 1'b0, busy: 1'b0};
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg    <= kind;
            tx_byte_reg <= tx_byte;
            ack_bit_reg <= ack_bit;
            sda_in_reg  <= sda_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_level = res_reg.scl_level;
    assign sda_level = res_reg.sda_level;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign rx_byte   = res_reg.rx_byte;
    assign ack_seen  = res_reg.ack_seen;
    assign rejected  = res_reg.rejected;

    `I2CMS_ASSERT_IMPLY(a_done_idle, out_valid_reg && done_res, !busy_res, "done while busy")
    `I2CMS_ASSERT_IMPLY(a_done_rej, out_valid_reg && done_res, !rejected, "done with reject")
    `I2CMS_ASSERT_IMPLY(a_stall_src, in_stall, s1_valid_reg && out_valid_reg, "stall while free")
    `I2CMS_ASSERT_ALWAYS(a_phase_range, st_reg.phase < MAX_PHASES, "phase out of range")
    `I2CMS_ASSERT_NEXT(a_state_hold, !advance, $stable(st_reg), "state moved without a transfer")

endmodule
